### src/glm_pkg.sv
`timescale 1ns / 1ps

package glm_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 1024;
  localparam int SAMPLE_W   = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = 6;
  localparam int HGT_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // Values broadcast from the control logic to every column cell.
  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic                wr;
    logic                swap;
    logic                row_gt1;
    logic [WID_W-1:0]    width;
    logic [SAMPLE_W-1:0] sample;
  } glm_bcast_t;

endpackage

### src/glm_cell.sv
`timescale 1ns / 1ps

module glm_cell (
  input  logic                           clk_i,
  input  logic [glm_pkg::COL_W-1:0]      idx_i,
  input  glm_pkg::glm_bcast_t            bc_i,
  input  logic [glm_pkg::SAMPLE_W-1:0]   left_mid_i,
  input  logic [glm_pkg::SAMPLE_W-1:0]   right_mid_i,
  input  logic [glm_pkg::SAMPLE_W-1:0]   left_up_i,
  input  logic [glm_pkg::SAMPLE_W-1:0]   right_up_i,
  output logic [glm_pkg::SAMPLE_W-1:0]   mid_o,
  output logic [glm_pkg::SAMPLE_W-1:0]   up_o,
  output logic                           pk_mid_o,
  output logic                           pk_last_o
);

  logic [glm_pkg::SAMPLE_W-1:0] mid_q, mid_d;
  logic [glm_pkg::SAMPLE_W-1:0] up_q, up_d;
  logic                         hit;
  logic                         has_left;
  logic                         has_right;
  logic                         in_grid;

  assign hit       = bc_i.wr && (bc_i.col == idx_i);
  assign has_left  = (idx_i != '0);
  assign has_right = (({1'b0, idx_i} + glm_pkg::WID_W'(1)) < bc_i.width);
  assign in_grid   = ({1'b0, idx_i} < bc_i.width);

  assign mid_o = mid_q;
  assign up_o  = hit ? bc_i.sample : up_q;

  assign pk_mid_o = (mid_q >= bc_i.sample)
                  && !(bc_i.row_gt1 && (mid_q < up_q))
                  && !(has_left && (mid_q < left_mid_i))
                  && !(has_right && (mid_q < right_mid_i));

  assign pk_last_o = in_grid && (up_o >= mid_q)
                   && !(has_left && (up_o < left_up_i))
                   && !(has_right && (up_o < right_up_i));

  always_comb begin
    mid_d = mid_q;
    up_d  = up_q;
    if (bc_i.wr && bc_i.swap) begin
      mid_d = up_o;
      up_d  = mid_q;
    end else if (hit) begin
      up_d = bc_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    up_q  <= up_d;
  end

endmodule

### src/grid_local_maximum_finder_core.sv
`timescale 1ns / 1ps

// Four-neighbor local maximum finder over a raster-ordered grid.
// Input items (s_axis) carry one unsigned sample each, in raster order. Result
// items (m_axis) carry the row and column of a cell that is greater than or
// equal to each of its in-grid neighbors; tlast marks the last result caused
// by the final sample of a grid. The grid size is set through the cfg port,
// which the user must write only while the block is idle; the block does not enforce this.
// A row of 32 column cells holds the two line buffers. The verdict for the
// cell above an accepted sample is known in the same cycle and appears on
// m_axis in the cycle after acceptance, so one item per cycle is sustained
// while the receiver keeps up.
// After the final sample of a grid, if the last row holds peaks, a scan of
// the column cells emits them at one column per cycle while the output
// register is free; no input item is accepted during that scan.
// A result waits in the output register while m_axis_tready is low; a new
// input item is accepted in the cycle that register empties or is taken.
// Reset clears the counters and the output valid, and sets the width to 32
// and the height to 2. Line buffer contents are not cleared.
module grid_local_maximum_finder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [glm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [glm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // [15:0] sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [9:0] peak_row, [14:10] peak_col
  output logic                             m_axis_tlast    // run_last
);

  localparam int MW = glm_pkg::MAX_WIDTH;
  localparam int SW = glm_pkg::SAMPLE_W;
  localparam int CW = glm_pkg::COL_W;
  localparam int RW = glm_pkg::ROW_W;
  localparam int WW = glm_pkg::WID_W;
  localparam int HW = glm_pkg::HGT_W;

  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [CW-1:0] col_q, col_d, col_eff;
  logic [RW-1:0] row_q, row_d, row_eff;
  logic          end_of_row;
  logic          is_final;
  logic          in_ack;
  logic          out_free;

  logic          flush_q, flush_d;
  logic [CW-1:0] flush_idx_q, flush_idx_d;
  logic [RW-1:0] flush_row_q, flush_row_d;

  logic          out_valid_q, out_valid_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic          out_last_q, out_last_d;

  glm_pkg::glm_bcast_t     bc;
  logic [MW-1:0][SW-1:0]   mid;
  logic [MW-1:0][SW-1:0]   up;
  logic [MW-1:0]           pk_mid;
  logic [MW-1:0]           pk_last;
  logic                    mask_any;
  logic                    above_any;

  always_comb begin
    width_eff = width_q;
    if (width_q < WW'(2)) begin
      width_eff = WW'(2);
    end else if (width_q > WW'(MW)) begin
      width_eff = WW'(MW);
    end
    height_eff = height_q;
    if (height_q < HW'(2)) begin
      height_eff = HW'(2);
    end else if (height_q > HW'(glm_pkg::MAX_HEIGHT)) begin
      height_eff = HW'(glm_pkg::MAX_HEIGHT);
    end
  end

  assign col_eff = ({1'b0, col_q} >= width_eff) ? CW'(width_eff - WW'(1)) : col_q;
  assign row_eff = ({1'b0, row_q} >= height_eff) ? RW'(height_eff - HW'(1)) : row_q;
  assign end_of_row = (({1'b0, col_eff} + WW'(1)) == width_eff);
  assign is_final   = end_of_row && (({1'b0, row_eff} + HW'(1)) == height_eff);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = out_free && !flush_q;
  assign in_ack        = s_axis_tvalid && s_axis_tready;

  assign bc.col     = col_eff;
  assign bc.wr      = in_ack;
  assign bc.swap    = end_of_row && !is_final;
  assign bc.row_gt1 = (row_eff > RW'(1));
  assign bc.width   = width_eff;
  assign bc.sample  = s_axis_tdata[SW-1:0];

  for (genvar i = 0; i < MW; i++) begin : g_cell
    logic [SW-1:0] left_mid, right_mid, left_up, right_up;
    if (i == 0) begin : g_first
      assign left_mid = '0;
      assign left_up  = '0;
    end else begin : g_inner_left
      assign left_mid = mid[i-1];
      assign left_up  = up[i-1];
    end
    if (i == MW - 1) begin : g_last
      assign right_mid = '0;
      assign right_up  = '0;
    end else begin : g_inner_right
      assign right_mid = mid[i+1];
      assign right_up  = up[i+1];
    end
    glm_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (CW'(i)),
      .bc_i        (bc),
      .left_mid_i  (left_mid),
      .right_mid_i (right_mid),
      .left_up_i   (left_up),
      .right_up_i  (right_up),
      .mid_o       (mid[i]),
      .up_o        (up[i]),
      .pk_mid_o    (pk_mid[i]),
      .pk_last_o   (pk_last[i])
    );
  end

  assign mask_any  = |pk_last;
  assign above_any = |((pk_last >> flush_idx_q) >> 1);

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    flush_d     = flush_q;
    flush_idx_d = flush_idx_q;
    flush_row_d = flush_row_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;

    if (in_ack) begin
      if (is_final) begin
        col_d       = '0;
        row_d       = '0;
        flush_d     = mask_any;
        flush_idx_d = '0;
        flush_row_d = row_eff;
      end else if (end_of_row) begin
        col_d = '0;
        row_d = row_eff + RW'(1);
      end else begin
        col_d = col_eff + CW'(1);
      end
      if ((row_eff != '0) && pk_mid[col_eff]) begin
        out_valid_d = 1'b1;
        out_row_d   = row_eff - RW'(1);
        out_col_d   = col_eff;
        out_last_d  = is_final && !mask_any;
      end
    end else if (flush_q && out_free) begin
      if (pk_last[flush_idx_q]) begin
        out_valid_d = 1'b1;
        out_row_d   = flush_row_q;
        out_col_d   = flush_idx_q;
        out_last_d  = !above_any;
      end
      if (!above_any) begin
        flush_d = 1'b0;
      end else begin
        flush_idx_d = flush_idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WW'(MW);
      height_q    <= HW'(2);
      col_q       <= '0;
      row_q       <= '0;
      flush_q     <= 1'b0;
      flush_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          glm_pkg::CFG_GRID_WIDTH:  width_q  <= cfg_data_i[WW-1:0];
          glm_pkg::CFG_GRID_HEIGHT: height_q <= cfg_data_i[HW-1:0];
          default: ;
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      flush_q     <= flush_d;
      flush_idx_q <= flush_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flush_row_q <= flush_row_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

  a_no_input_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !s_axis_tready)
    else $error("input accepted during last-row scan");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ack && is_final && mask_any) |=> (flush_q && (flush_idx_q == '0)))
    else $error("last-row scan did not start at column zero");

  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> !flush_q)
    else $error("last result shown while scan still running");

endmodule

### verif/tb_grid_local_maximum_finder_core.sv
`timescale 1ns / 1ps

module tb_grid_local_maximum_finder_core;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_BUDGET = 410;

  typedef struct packed {
    logic                      last;
    logic [glm_pkg::COL_W-1:0] col;
    logic [glm_pkg::ROW_W-1:0] row;
  } peak_t;

  typedef enum {STEP_WIDTH, STEP_HEIGHT, STEP_SAMPLE} step_e;
  typedef enum {FILL_ANY, FILL_PLATEAU, FILL_RAILS, FILL_MIDSCALE} fill_e;

  typedef struct {
    step_e       kind;
    int unsigned val;
    int          n;
    peak_t       exp0;
    peak_t       exp1;
    peak_t       exp2;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [glm_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [glm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [15:0]                    in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [15:0]                    out_data;
  logic                           out_last;

  grid_local_maximum_finder_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tlast  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Peak predictor state: prev_line holds the previous row, older_line the row
  // before it in columns not yet reached and the current row elsewhere.
  logic [glm_pkg::WID_W-1:0]    grid_w_reg = 6'd32;
  logic [glm_pkg::HGT_W-1:0]    grid_h_reg = 11'd2;
  logic [glm_pkg::SAMPLE_W-1:0] older_line [glm_pkg::MAX_WIDTH];
  logic [glm_pkg::SAMPLE_W-1:0] prev_line [glm_pkg::MAX_WIDTH];
  int unsigned                  row_ctr = 0;
  int unsigned                  col_ctr = 0;

  peak_t pending_peaks[$];
  peak_t typed_res [3];
  int    typed_n = -1;
  bit    steady = 1'b0;
  int    mismatches = 0;
  int    samples_in = 0;
  int    peaks_seen = 0;
  int    cfg_writes = 0;
  int    idle_cycles = 0;
  int    n_rand = 0;
  dir_row_t dir_tab[$];

  function automatic int unsigned eff_w();
    if (grid_w_reg < 2) return 2;
    if (grid_w_reg > glm_pkg::MAX_WIDTH) return glm_pkg::MAX_WIDTH;
    return grid_w_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (grid_h_reg < 2) return 2;
    if (grid_h_reg > glm_pkg::MAX_HEIGHT) return glm_pkg::MAX_HEIGHT;
    return grid_h_reg;
  endfunction

  function automatic peak_t peak_at(int unsigned r, int unsigned c, logic last);
    peak_t p;
    p.row = glm_pkg::ROW_W'(r);
    p.col = glm_pkg::COL_W'(c);
    p.last = last;
    return p;
  endfunction

  task automatic predict_peaks(input logic [glm_pkg::SAMPLE_W-1:0] s);
    int unsigned w, h, c, r, n0, x;
    logic [glm_pkg::SAMPLE_W-1:0] v;
    logic pk;
    logic [glm_pkg::SAMPLE_W-1:0] keep [glm_pkg::MAX_WIDTH];
    peak_t tail;
    w = eff_w();
    h = eff_h();
    c = col_ctr;
    r = row_ctr;
    n0 = pending_peaks.size();
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    if (r > 0) begin
      v = prev_line[c];
      pk = (v >= s);
      if (r > 1 && v < older_line[c]) pk = 1'b0;
      if (c > 0 && v < prev_line[c-1]) pk = 1'b0;
      if (c + 1 < w && v < prev_line[c+1]) pk = 1'b0;
      if (pk) pending_peaks.push_back(peak_at(r - 1, c, 1'b0));
    end
    older_line[c] = s;
    if (c + 1 >= w) begin
      if (r + 1 >= h) begin
        for (x = 0; x < w; x++) begin
          v = older_line[x];
          pk = (v >= prev_line[x]);
          if (x > 0 && v < older_line[x-1]) pk = 1'b0;
          if (x + 1 < w && v < older_line[x+1]) pk = 1'b0;
          if (pk) pending_peaks.push_back(peak_at(r, x, 1'b0));
        end
        if (pending_peaks.size() > n0) begin
          tail = pending_peaks.pop_back();
          tail.last = 1'b1;
          pending_peaks.push_back(tail);
        end
        row_ctr = 0;
        col_ctr = 0;
      end else begin
        keep = prev_line;
        prev_line = older_line;
        older_line = keep;
        row_ctr = r + 1;
        col_ctr = 0;
      end
    end else begin
      col_ctr = c + 1;
    end
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    int unsigned n0;
    peak_t got;
    peak_t want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we) begin
        if (cfg_idx == glm_pkg::CFG_GRID_WIDTH) begin
          grid_w_reg = cfg_data[glm_pkg::WID_W-1:0];
        end else if (cfg_idx == glm_pkg::CFG_GRID_HEIGHT) begin
          grid_h_reg = cfg_data[glm_pkg::HGT_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        samples_in++;
        n0 = pending_peaks.size();
        predict_peaks(in_data);
        if (typed_n >= 0) begin
          while (pending_peaks.size() > n0) void'(pending_peaks.pop_back());
          for (int k = 0; k < typed_n; k++) pending_peaks.push_back(typed_res[k]);
        end
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        peaks_seen++;
        got.row = out_data[glm_pkg::ROW_W-1:0];
        got.col = out_data[glm_pkg::ROW_W+glm_pkg::COL_W-1:glm_pkg::ROW_W];
        got.last = out_last;
        if (pending_peaks.size() == 0) begin
          flag_error($sformatf("unexpected peak at row %0d col %0d", got.row, got.col));
        end else begin
          want = pending_peaks.pop_front();
          if (got.row != want.row)
            flag_error($sformatf("peak row %0d, expected %0d", got.row, want.row));
          if (got.col != want.col)
            flag_error($sformatf("peak col %0d, expected %0d (row %0d)",
                                 got.col, want.col, want.row));
          if (got.last != want.last)
            flag_error($sformatf("tlast %0d, expected %0d (row %0d col %0d)",
                                 got.last, want.last, want.row, want.col));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(0, 99) >= 21);
  end

  function automatic logic [15:0] pick_sample(input fill_e f);
    case (f)
      FILL_PLATEAU:  return 16'($urandom_range(0, 3));
      FILL_RAILS:    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      FILL_MIDSCALE: return 16'($urandom_range(16'h7FFC, 16'h8003));
      default:       return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with the valid still high.
  task automatic send_sample(input logic [15:0] s);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic feed_one(input fill_e f);
    send_sample(pick_sample(f));
    n_rand++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [glm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [glm_pkg::CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  task automatic set_size(input logic [glm_pkg::CFG_DATA_W-1:0] wval,
                          input logic [glm_pkg::CFG_DATA_W-1:0] hval);
    settle();
    write_reg(glm_pkg::CFG_GRID_WIDTH, wval);
    write_reg(glm_pkg::CFG_GRID_HEIGHT, hval);
  endtask

  task automatic feed_grids(input int n, input fill_e f);
    repeat (n) begin
      feed_one(f);
      while (row_ctr != 0 || col_ctr != 0) feed_one(f);
    end
  endtask

  task automatic add_step(input step_e kind, input int unsigned val, input int n = -1,
                          input peak_t e0 = '0, input peak_t e1 = '0, input peak_t e2 = '0);
    dir_tab.push_back('{kind, val, n, e0, e1, e2});
  endtask

  initial begin : stimulus
    int unsigned weff, heff, wv, hv, nw, k;
    fill_e f;

    // A 2x2 grid with one high cell per row.
    add_step(STEP_WIDTH, 2);
    add_step(STEP_HEIGHT, 2);
    add_step(STEP_SAMPLE, 16'h0000, 0);
    add_step(STEP_SAMPLE, 16'hFFFF, 0);
    add_step(STEP_SAMPLE, 16'hFFFF, 0);
    add_step(STEP_SAMPLE, 16'h0000, 2, peak_at(0, 1, 0), peak_at(1, 0, 1));
    // Sizes below the minimum act as 2; a flat grid makes every cell a peak.
    add_step(STEP_WIDTH, 0);
    add_step(STEP_HEIGHT, 1);
    add_step(STEP_SAMPLE, 16'hFFFF, 0);
    add_step(STEP_SAMPLE, 16'hFFFF, 0);
    add_step(STEP_SAMPLE, 16'hFFFF, 1, peak_at(0, 0, 0));
    add_step(STEP_SAMPLE, 16'hFFFF, 3, peak_at(0, 1, 0), peak_at(1, 0, 0), peak_at(1, 1, 1));
    // No peak in the last row, so the final item yields nothing.
    add_step(STEP_WIDTH, 3);
    add_step(STEP_HEIGHT, 2);
    add_step(STEP_SAMPLE, 9);
    add_step(STEP_SAMPLE, 9);
    add_step(STEP_SAMPLE, 2);
    add_step(STEP_SAMPLE, 0);
    add_step(STEP_SAMPLE, 0);
    add_step(STEP_SAMPLE, 1);
    // Size shrinks in the middle of a grid, so the counters saturate.
    add_step(STEP_WIDTH, 4);
    add_step(STEP_HEIGHT, 4);
    add_step(STEP_SAMPLE, 5);
    add_step(STEP_SAMPLE, 1);
    add_step(STEP_SAMPLE, 8);
    add_step(STEP_SAMPLE, 3);
    add_step(STEP_SAMPLE, 2);
    add_step(STEP_SAMPLE, 7);
    add_step(STEP_WIDTH, 11'h7C2);
    add_step(STEP_SAMPLE, 4);
    add_step(STEP_SAMPLE, 6);
    add_step(STEP_SAMPLE, 0);
    add_step(STEP_HEIGHT, 2);
    add_step(STEP_SAMPLE, 9);
    add_step(STEP_SAMPLE, 3);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        STEP_WIDTH: begin
          settle();
          write_reg(glm_pkg::CFG_GRID_WIDTH, glm_pkg::CFG_DATA_W'(dir_tab[i].val));
        end
        STEP_HEIGHT: begin
          settle();
          write_reg(glm_pkg::CFG_GRID_HEIGHT, glm_pkg::CFG_DATA_W'(dir_tab[i].val));
        end
        default: begin
          typed_n = dir_tab[i].n;
          typed_res[0] = dir_tab[i].exp0;
          typed_res[1] = dir_tab[i].exp1;
          typed_res[2] = dir_tab[i].exp2;
          send_sample(16'(dir_tab[i].val));
          typed_n = -1;
        end
      endcase
    end

    set_size(11'd32, 11'd2);
    feed_grids(1, FILL_ANY);
    set_size(11'd63, 11'd3);
    feed_grids(1, FILL_PLATEAU);
    set_size(11'h7E1, 11'd0);
    feed_grids(1, FILL_RAILS);

    // A full-width grid streamed with no idling on either side.
    set_size(11'd32, 11'd4);
    steady = 1'b1;
    feed_grids(1, FILL_PLATEAU);
    steady = 1'b0;

    while (n_rand < ITEM_BUDGET) begin
      weff = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 32) : $urandom_range(2, 10);
      heff = $urandom_range(2, (60 / weff > 2) ? 60 / weff : 2);
      wv = weff;
      hv = heff;
      if (weff == 2 && $urandom_range(0, 1)) wv = $urandom_range(0, 1);
      if (weff == 32 && $urandom_range(0, 1)) wv = $urandom_range(33, 63);
      if (heff == 2 && $urandom_range(0, 1)) hv = $urandom_range(0, 1);
      f = fill_e'($urandom_range(0, 3));
      set_size({5'($urandom), 6'(wv)}, 11'(hv));
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, weff * heff - 1);
        repeat (k) feed_one(f);
        settle();
        nw = $urandom_range(2, eff_w());
        write_reg(glm_pkg::CFG_GRID_WIDTH, {5'($urandom), 6'(nw)});
        if ($urandom_range(0, 1)) begin
          write_reg(glm_pkg::CFG_GRID_HEIGHT, 11'($urandom_range(2, 6)));
        end
        while (row_ctr != 0 || col_ctr != 0) feed_one(f);
      end else begin
        feed_grids($urandom_range(1, 2), f);
      end
    end

    settle();
    if (pending_peaks.size() != 0)
      flag_error($sformatf("%0d peaks never arrived", pending_peaks.size()));

    $display("Fed %0d samples through %0d register writes, including a full-width grid",
             samples_in, cfg_writes);
    $display("with no idling, and checked %0d peaks with %0d mismatches.",
             peaks_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/glm_pkg.sv
src/glm_cell.sv
src/grid_local_maximum_finder_core.sv
verif/tb_grid_local_maximum_finder_core.sv
